// ===== hw/rtl/pfs_pkg.sv =====
`default_nettype none
package pfs_pkg;

  // Quotient bits produced by the per-lane restoring divider.
  localparam int unsigned DivSteps = 32;
  localparam int unsigned RateW = 16;
  localparam int unsigned AvgW = 32;
  localparam int unsigned WinW = 16;

  // Configuration register indexes.
  localparam logic CfgActiveUsers = 1'b0;
  localparam logic CfgEwmaSlots = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEL,
    S_PUSH,
    S_MUL,
    S_DIV
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pfs_lane.sv =====
`default_nettype none
module pfs_lane (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire pfs_pkg::lane_ctrl_t            ctrl_i,
  input  wire logic                           active_i,
  input  wire logic                           chosen_i,
  input  wire logic [pfs_pkg::RateW-1:0]      rate_i,
  input  wire logic [pfs_pkg::WinW-1:0]       win_i,
  input  wire logic                           wr_avg_i,
  output logic [pfs_pkg::AvgW-1:0]            avg_o
);

  logic [pfs_pkg::AvgW-1:0] avg_q, avg_d;
  logic [pfs_pkg::WinW:0]   rem_q, rem_d;
  logic [pfs_pkg::AvgW-1:0] quo_q, quo_d;
  logic [47:0]              acc;
  logic [pfs_pkg::WinW:0]   trial;
  logic                     fits;

  always_comb begin
    acc = 48'(avg_q) * 48'(win_i - 16'd1);
    if (chosen_i) begin
      acc = acc + {16'd0, rate_i, 16'd0};
    end
    trial = {rem_q[pfs_pkg::WinW-1:0], quo_q[pfs_pkg::AvgW-1]};
    fits = trial >= {1'b0, win_i};
    rem_d = rem_q;
    quo_d = quo_q;
    if (ctrl_i.load) begin
      rem_d = {1'b0, acc[47:32]};
      quo_d = acc[31:0];
    end else if (ctrl_i.step) begin
      rem_d = fits ? (trial - {1'b0, win_i}) : trial;
      quo_d = {quo_q[pfs_pkg::AvgW-2:0], fits};
    end
    avg_d = avg_q;
    // The write comes with the last division step, so the new quotient bit
    // is taken straight from the step logic.
    if (wr_avg_i && active_i) begin
      avg_d = quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else begin
      avg_q <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign avg_o = avg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pfs_select.sv =====
`default_nettype none
module pfs_select #(
  parameter int unsigned MAX_USERS = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic [$clog2(MAX_USERS+1)-1:0]         n_i,
  input  wire logic [MAX_USERS-1:0][pfs_pkg::RateW-1:0] rate_i,
  input  wire logic [MAX_USERS-1:0][pfs_pkg::AvgW-1:0]  avg_i,
  output logic                                        done_o,
  output logic [$clog2(MAX_USERS)-1:0]                best_o,
  output logic [pfs_pkg::RateW-1:0]                   best_rate_o
);

  localparam int unsigned CW = $clog2(MAX_USERS + 1);
  localparam int unsigned UW = $clog2(MAX_USERS);

  logic                     busy_q, busy_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [UW-1:0]            best_q, best_d;
  logic [pfs_pkg::RateW-1:0] brate_q, brate_d;
  logic [pfs_pkg::AvgW-1:0]  bavg_q, bavg_d;
  logic [pfs_pkg::RateW-1:0] crate;
  logic [pfs_pkg::AvgW-1:0]  cavg;
  logic [47:0]              lhs, rhs;
  logic                     greater;

  always_comb begin
    crate = rate_i[idx_q[UW-1:0]];
    cavg = avg_i[idx_q[UW-1:0]];
    lhs = 48'(crate) * 48'(bavg_q);
    rhs = 48'(brate_q) * 48'(cavg);
    // A zero average is an infinite ratio; a tie keeps the lower index.
    greater = (bavg_q != '0) && ((cavg == '0) || (lhs > rhs));
    done_o = busy_q && (idx_q >= n_i);
    busy_d = busy_q;
    idx_d = idx_q;
    best_d = best_q;
    brate_d = brate_q;
    bavg_d = bavg_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d = CW'(1);
      best_d = '0;
      brate_d = rate_i[0];
      bavg_d = avg_i[0];
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      idx_d = idx_q + CW'(1);
      if (greater) begin
        best_d = idx_q[UW-1:0];
        brate_d = crate;
        bavg_d = cavg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    best_q <= best_d;
    brate_q <= brate_d;
    bavg_q <= bavg_d;
  end

  assign best_o = best_q;
  assign best_rate_o = brate_q;

endmodule
`default_nettype wire

// ===== hw/rtl/proportional_fair_user_scheduler_top.sv =====
// Proportional-fair user scheduler.
// Each request on the slave stream is one time slot and carries the current
// rate of every user. The block picks the active user with the largest ratio
// of rate to its running average and sends that user and its rate as one
// request on the master stream. All active averages then decay, and the
// chosen user's average gains rate/window.
// Sequence: after a request is taken, the selection starts once the rates
// are registered, the walk then goes through the active users (one user per
// cycle through a shared cross-multiply), then the result is posted, and
// every user lane does its multiply and then its restoring division, all
// lanes at once. The next request is taken only once the division is done.
// The result sits in an output register; if the receiver stalls, the block
// waits in the posting step, before the averages are updated, until the old
// result has been taken.
// Reset clears all averages to zero and sets active_users to 8 and the
// window to 100 slots. Configuration writes are taken at any time, but
// should only be issued while the block is idle.
`default_nettype none
module proportional_fair_user_scheduler_top #(
  parameter int unsigned MAX_USERS = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // rate_user0 .. rate_user7, 16 bits each, from the lowest bit up
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // chosen_user [2:0], chosen_rate [18:3], zero padding [23:19]
  output logic [23:0]       m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [15:0]  cfg_wdata_i
);

  localparam int unsigned CW = $clog2(MAX_USERS + 1);
  localparam int unsigned UW = $clog2(MAX_USERS);

  pfs_pkg::state_e state_q, state_d;

  logic [3:0]  active_q;
  logic [15:0] slots_q;
  logic [CW-1:0] n_eff;
  logic [pfs_pkg::WinW-1:0] win;

  logic [MAX_USERS-1:0][pfs_pkg::RateW-1:0] rate_q;
  logic [MAX_USERS-1:0][pfs_pkg::AvgW-1:0]  avg;

  logic [4:0]  div_cnt_q, div_cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_user_q;
  logic [15:0] out_rate_q;

  logic        accept, sel_start, sel_done, push;
  logic        start_q;
  logic [UW-1:0] best;
  logic [UW-1:0] best_hold_q;
  logic [pfs_pkg::RateW-1:0] best_rate;
  pfs_pkg::lane_ctrl_t lane_ctrl;
  logic        wr_avg;

  // Out-of-range settings are folded to the nearest legal value.
  always_comb begin
    if (active_q == 4'd0) begin
      n_eff = CW'(1);
    end else if (32'(active_q) > MAX_USERS) begin
      n_eff = CW'(MAX_USERS);
    end else begin
      n_eff = CW'(active_q);
    end
    win = (slots_q == 16'd0) ? 16'd1 : slots_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 4'd8;
      slots_q <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfs_pkg::CfgActiveUsers: active_q <= cfg_wdata_i[3:0];
        pfs_pkg::CfgEwmaSlots:   slots_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfs_pkg::S_IDLE: if (s_axis_tvalid) state_d = pfs_pkg::S_SEL;
      pfs_pkg::S_SEL:  if (sel_done) state_d = pfs_pkg::S_PUSH;
      pfs_pkg::S_PUSH: if (!out_valid_q || m_axis_tready) state_d = pfs_pkg::S_MUL;
      pfs_pkg::S_MUL:  state_d = pfs_pkg::S_DIV;
      pfs_pkg::S_DIV:  if (div_cnt_q == 5'(pfs_pkg::DivSteps - 1)) state_d = pfs_pkg::S_IDLE;
      default:         state_d = pfs_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer. The selection starts in the cycle after the
  // request is taken, once the rates are held in rate_q.
  always_comb begin
    s_axis_tready = (state_q == pfs_pkg::S_IDLE);
    accept = s_axis_tready && s_axis_tvalid;
    sel_start = start_q;
    push = (state_q == pfs_pkg::S_PUSH) && (!out_valid_q || m_axis_tready);
    lane_ctrl.load = (state_q == pfs_pkg::S_MUL);
    lane_ctrl.step = (state_q == pfs_pkg::S_DIV);
    wr_avg = (state_q == pfs_pkg::S_DIV) &&
             (div_cnt_q == 5'(pfs_pkg::DivSteps - 1));
    div_cnt_d = (state_q == pfs_pkg::S_DIV) ? div_cnt_q + 5'd1 : 5'd0;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (push) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfs_pkg::S_IDLE;
      div_cnt_q <= 5'd0;
      out_valid_q <= 1'b0;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      div_cnt_q <= div_cnt_d;
      out_valid_q <= out_valid_d;
      start_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < MAX_USERS; i++) begin
        rate_q[i] <= s_axis_tdata[16*i +: 16];
      end
    end
    if (sel_done) begin
      best_hold_q <= best;
    end
    if (push) begin
      out_user_q <= 3'(best_hold_q);
      out_rate_q <= best_rate;
    end
  end

  pfs_select #(
    .MAX_USERS(MAX_USERS)
  ) u_select (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sel_start),
    .n_i        (n_eff),
    .rate_i     (rate_q),
    .avg_i      (avg),
    .done_o     (sel_done),
    .best_o     (best),
    .best_rate_o(best_rate)
  );

  for (genvar g = 0; g < MAX_USERS; g++) begin : g_lane
    pfs_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .active_i(CW'(g) < n_eff),
      .chosen_i(UW'(g) == best_hold_q),
      .rate_i  (rate_q[g]),
      .win_i   (win),
      .wr_avg_i(wr_avg),
      .avg_o   (avg[g])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {5'd0, out_rate_q, out_user_q};

endmodule
`default_nettype wire

// ===== dv/proportional_fair_user_scheduler_checker.sv =====
`default_nettype none
module proportional_fair_user_scheduler_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         slot_valid_i,
  input  wire logic         slot_ready_i,
  input  wire logic [127:0] slot_rates_i,
  input  wire logic         grant_valid_i,
  input  wire logic         grant_ready_i,
  input  wire logic [23:0]  grant_data_i,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [15:0]  cfg_wdata_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_grants_o
);

  typedef struct packed {
    logic [2:0]  user;
    logic [15:0] rate;
  } grant_t;

  logic [31:0] avg_q [8];
  logic [3:0]  users_q;
  logic [15:0] window_q;
  grant_t      grant_queue [$];

  // A zero average is an infinite ratio; ties keep the lower index.
  function automatic bit beats(logic [15:0] ri, logic [31:0] ai,
                               logic [15:0] rb, logic [31:0] ab);
    logic [47:0] lhs;
    logic [47:0] rhs;
    if (ab == 0) return 1'b0;
    if (ai == 0) return 1'b1;
    lhs = ri * ab;
    rhs = rb * ai;
    return lhs > rhs;
  endfunction

  task automatic schedule_slot(input logic [127:0] rates);
    int unsigned n;
    int unsigned win;
    int unsigned best;
    logic [63:0] acc;
    grant_t g;
    n = (users_q == 0) ? 1 : ((users_q > 8) ? 8 : users_q);
    win = (window_q == 0) ? 1 : window_q;
    best = 0;
    for (int i = 1; i < n; i++)
      if (beats(rates[16*i +: 16], avg_q[i], rates[16*best +: 16], avg_q[best])) best = i;
    g.user = best[2:0];
    g.rate = rates[16*best +: 16];
    grant_queue.push_back(g);
    for (int i = 0; i < n; i++) begin
      acc = 64'(avg_q[i]) * 64'(win - 1);
      if (i == best) acc += 64'(rates[16*i +: 16]) << 16;
      avg_q[i] = 32'(acc / win);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t got;
    grant_t exp_g;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) avg_q[i] = '0;
      users_q      <= 4'd8;
      window_q     <= 16'd100;
      fail_count_o <= 0;
      grant_queue.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == pfs_pkg::CfgActiveUsers) users_q <= cfg_wdata_i[3:0];
        else window_q <= cfg_wdata_i;
      end
      if (slot_valid_i && slot_ready_i) schedule_slot(slot_rates_i);
      if (grant_valid_i && grant_ready_i) begin
        got.user = grant_data_i[2:0];
        got.rate = grant_data_i[18:3];
        if (grant_queue.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected grant user=%0d rate=%0d",
                                          got.user, got.rate);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_g = grant_queue.pop_front();
          if (exp_g != got) begin
            if (fail_count_o < 10)
              $display("grant mismatch: expected user=%0d rate=%0d, got user=%0d rate=%0d",
                       exp_g.user, exp_g.rate, got.user, got.rate);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_grants_o = grant_queue.size();
endmodule
`default_nettype wire

// ===== dv/proportional_fair_user_scheduler_top_test.sv =====
`default_nettype none
// Stimulus and verdict for the proportional-fair scheduler. The checker
// beside the block predicts every grant and counts mismatches; this module
// only drives time slots, configuration and back-pressure.
module proportional_fair_user_scheduler_top_test;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // rate_user0 .. rate_user7, 16 bits each, from the lowest bit up
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // chosen_user [2:0], chosen_rate [18:3], zero padding [23:19]
  logic [23:0]  m_axis_tdata;
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [15:0]  cfg_wdata_i;
  int unsigned  fail_count;
  int unsigned  pending_grants;
  bit           stall_enable;

  // Settings visited: active users and window, the extremes and
  // out-of-range values among them.
  logic [3:0]  user_set [8]  = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5, 4'd8};
  logic [15:0] win_set [8]   = '{16'd100, 16'd1, 16'd0, 16'd65535, 16'd2, 16'd7, 16'd16,
                                 16'd1000};

  proportional_fair_user_scheduler_top DUT (.*);

  proportional_fair_user_scheduler_checker u_checker (
    .clk_i, .rst_ni,
    .slot_valid_i(s_axis_tvalid), .slot_ready_i(s_axis_tready),
    .slot_rates_i(s_axis_tdata),
    .grant_valid_i(m_axis_tvalid), .grant_ready_i(m_axis_tready),
    .grant_data_i(m_axis_tdata),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_grants_o(pending_grants)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
  endfunction

  // The receiver stalls at random whenever stalls are enabled.
  always @(posedge clk_i) begin
    if (!rst_ni || !stall_enable) m_axis_tready <= 1'b1;
    else m_axis_tready <= (gap_length() == 0);
  end

  // Offer one slot, hold it until accepted, then drop valid for a random gap, if any.
  task automatic send_slot(input logic [127:0] rates);
    int unsigned gap;
    s_axis_tdata  <= rates;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = gap_length();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Let every grant arrive, then allow the block time to finish its
  // averaging divisions before configuration is touched.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_grants != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [127:0] random_rates();
    logic [127:0] r;
    int unsigned style;
    style = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) begin
      case (style)
        0:       r[16*i +: 16] = 16'(($urandom_range(0, 3) == 0) ? 0 : 16'hFFFF);
        1:       r[16*i +: 16] = 16'($urandom_range(0, 3));
        2:       r[16*i +: 16] = 16'd1000;
        default: r[16*i +: 16] = 16'($urandom);
      endcase
    end
    return r;
  endfunction

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = pfs_pkg::CfgActiveUsers;
    cfg_wdata_i   = '0;
    stall_enable  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed slots under reset settings: all zero averages tie, extremes,
    // equal ratios and an all-zero slot.
    send_slot('0);
    send_slot({8{16'hFFFF}});
    send_slot({8{16'hFFFF}});
    send_slot({16'hFFFF, 112'h0});
    send_slot({8{16'h0001}});
    for (int i = 0; i < 8; i++) send_slot(128'h1 << (16 * i));
    send_slot({8{16'h8000}});
    send_slot(128'h5555_AAAA_5555_AAAA_5555_AAAA_5555_AAAA);
    drain();

    stall_enable = 1'b1;
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(pfs_pkg::CfgActiveUsers, {12'h0, user_set[phase]});
      write_reg(pfs_pkg::CfgEwmaSlots, win_set[phase]);
      for (int k = 0; k < 250; k++) begin
        send_slot(random_rates());
        // Sender pause until every grant is in.
        if (k == 100) drain();
      end
      drain();
    end

    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
